// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// ante implies cons in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// ante implies cons in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/krgb_pkg.sv -----
`default_nettype none

package krgb_pkg;

    localparam int MAX_FRAME_WIDTH  = 512;
    localparam int MAX_FRAME_HEIGHT = 512;

    localparam int CHAN_W  = 8;
    localparam int DIM_W   = 10;
    localparam int COL_W   = $clog2(MAX_FRAME_WIDTH);
    localparam int ROW_W   = $clog2(MAX_FRAME_HEIGHT);
    localparam int PIX_W   = 15;
    localparam int WORD_W  = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(512);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [WORD_W-1:0] packed_word;
        logic              last_of_frame;
    } result_t;

    // Color key (magenta to black, near-black lifted), then RGB888 to RGB555.
    function automatic logic [PIX_W-1:0] key_and_pack(input pixel_t p);
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        r = p.red;
        g = p.green;
        b = p.blue;
        if (r == 8'hFF && g == 8'h00 && b == 8'hFF)
        begin
            r = '0;
            g = '0;
            b = '0;
        end
        else if (r < 8'd8 && g < 8'd8 && b < 8'd8)
        begin
            r = 8'd8;
        end
        return {r[7:3], g[7:3], b[7:3]};
    endfunction

    function automatic logic [WORD_W-1:0] reverse_bytes(input logic [WORD_W-1:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // Width: zero acts as one, saturates at the maximum.
    function automatic logic [DIM_W-1:0] eff_width(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] w;
        w = v;
        if (w == '0)
            w = DIM_W'(1);
        if (w > DIM_W'(MAX_FRAME_WIDTH))
            w = DIM_W'(MAX_FRAME_WIDTH);
        return w;
    endfunction

    // Height: saturate, force even, zero acts as two.
    function automatic logic [DIM_W-1:0] eff_height(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] h;
        h = v;
        if (h > DIM_W'(MAX_FRAME_HEIGHT))
            h = DIM_W'(MAX_FRAME_HEIGHT);
        h[0] = 1'b0;
        if (h == '0)
            h = DIM_W'(2);
        return h;
    endfunction

endpackage

`default_nettype wire

// ----- src/keyed_rgb555_row_pair_packer.sv -----
// Takes one RGB888 pixel per cycle in raster order, color-keys it and packs
// it to RGB555. Even-row pixels are stored in a 512-entry row memory and
// produce nothing; each odd-row pixel produces one 32-bit word, byte
// reversed, with the pixel above in the upper half and itself in the lower
// half; the frame's final word carries last_of_frame. A result passes
// through the memory read register, then the output register, and a
// pixel can be accepted every cycle while the output is
// drained. Writing frame_width (index 0) or frame_height (index 1) restarts
// the frame at row 0, column 0; write only while the block is idle.
`default_nettype none
`include "assert_macros.svh"

module keyed_rgb555_row_pair_packer
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [krgb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [krgb_pkg::DIM_W-1:0]          cfg_data,

    input  wire logic                                pixel_valid,
    output logic                                     pixel_ready,
    input  wire krgb_pkg::pixel_t                    pixel,

    output logic                                     word_valid,
    input  wire logic                                word_ready,
    output krgb_pkg::result_t                        word
);

    logic [krgb_pkg::DIM_W-1:0]   width_reg;
    logic [krgb_pkg::DIM_W-1:0]   height_reg;
    logic [krgb_pkg::COL_W-1:0]   col_reg;
    logic [krgb_pkg::COL_W-1:0]   col_next;
    logic [krgb_pkg::ROW_W-1:0]   row_reg;
    logic [krgb_pkg::ROW_W-1:0]   row_next;

    logic [krgb_pkg::PIX_W-1:0]   row_mem [krgb_pkg::MAX_FRAME_WIDTH];
    logic [krgb_pkg::PIX_W-1:0]   above_reg;

    logic                         s1_valid_reg;
    logic [krgb_pkg::PIX_W-1:0]   s1_pix_reg;
    logic                         s1_last_reg;

    logic                         out_valid_reg;
    krgb_pkg::result_t            out_reg;

    logic                         cfg_write;
    logic                         accept;
    logic                         s1_advance;
    logic                         odd_row;
    logic                         col_wrap;
    logic                         row_wrap;
    logic [krgb_pkg::PIX_W-1:0]   pix;

    assign cfg_ready   = 1'b1;
    assign cfg_write   = cfg_valid && cfg_ready &&
                         (cfg_index == krgb_pkg::CFG_FRAME_WIDTH ||
                          cfg_index == krgb_pkg::CFG_FRAME_HEIGHT);

    assign s1_advance  = !out_valid_reg || word_ready;
    assign pixel_ready = !s1_valid_reg || s1_advance;
    assign accept      = pixel_valid && pixel_ready;

    assign odd_row  = row_reg[0];
    assign col_wrap = ({1'b0, col_reg} + krgb_pkg::DIM_W'(1)) >= width_reg;
    assign row_wrap = ({1'b0, row_reg} + krgb_pkg::DIM_W'(1)) >= height_reg;
    assign pix      = krgb_pkg::key_and_pack(pixel);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_wrap)
        begin
            col_next = '0;
            row_next = row_wrap ? '0 : row_reg + krgb_pkg::ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + krgb_pkg::COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= krgb_pkg::DIM_RESET;
            height_reg    <= krgb_pkg::DIM_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == krgb_pkg::CFG_FRAME_WIDTH)
                    width_reg <= krgb_pkg::eff_width(cfg_data);
                else
                    height_reg <= krgb_pkg::eff_height(cfg_data);
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end

            if (accept)
                s1_valid_reg <= odd_row;
            else if (s1_advance)
                s1_valid_reg <= 1'b0;

            if (s1_advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Row memory: write on even rows, registered read on odd rows.
    always_ff @(posedge clk)
    begin
        if (accept && !odd_row)
            row_mem[col_reg] <= pix;
        if (accept && odd_row)
            above_reg <= row_mem[col_reg];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= pix;
            s1_last_reg <= col_wrap && row_wrap;
        end
        if (s1_advance && s1_valid_reg)
        begin
            out_reg.packed_word   <= krgb_pkg::reverse_bytes(
                                         {1'b0, above_reg, 1'b0, s1_pix_reg});
            out_reg.last_of_frame <= s1_last_reg;
        end
    end

    assign word_valid = out_valid_reg;
    assign word       = out_reg;

    `ASSERT_ALWAYS(a_col_in_row, clk, rst_n, {1'b0, col_reg} < width_reg)
    `ASSERT_ALWAYS(a_row_in_frame, clk, rst_n, {1'b0, row_reg} < height_reg)
    `ASSERT_ALWAYS(a_height_even, clk, rst_n, !height_reg[0])
    `ASSERT_NEXT(a_last_queued, clk, rst_n, accept && col_wrap && row_wrap, s1_valid_reg)

endmodule

`default_nettype wire
